@@ rtl/core/i2cmws_pkg.sv @@
// shared types and constants for the i2c master write sequencer
package i2cmws_pkg;

  // bus sequencer states
  typedef enum logic [2:0] {
    SeqIdle = 3'd0,
    SeqAddr = 3'd1,
    SeqCtrl = 3'd2,
    SeqData = 3'd3,
    SeqWait = 3'd4,
    SeqStop = 3'd5
  } seq_state_e;

  // input word kinds carried in tuser
  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  // configuration register indexes
  localparam logic CfgDevAddr = 1'b0;
  localparam logic CfgCtrlByte = 1'b1;

  // register reset values
  localparam logic [7:0] DevAddrRst  = 8'h78;
  localparam logic [7:0] CtrlByteRst = 8'h00;

  // ack slot sits after eight data bits
  localparam logic [3:0] AckSlot = 4'd8;
  // last phase of the stop sequence
  localparam logic [3:0] StopLast = 4'd2;

  // one bus phase result
  typedef struct packed {
    logic nack_seen;
    logic want_byte;
    logic sda_level;
    logic scl_level;
  } phase_res_t;

endpackage

@@ rtl/core/i2c_master_write_sequencer_unit.sv @@
// write-only i2c master sequencer, one bus phase per tick word
//
//  channel  | direction | handshake            | contents
//  s_axis   | in        | tvalid/tready        | tdata: data_byte, sda_in; tlast; tuser: opcode
//  m_axis   | out       | tvalid/tready        | tdata: scl, sda, want_byte, nack_seen
//  cfg      | in        | cfg_we_i, no wait    | cfg_idx_i selects address or control byte
//
// Each accepted word is handled in the cycle it is taken: one layer of logic updates the
// sequencer state and a tick writes its phase result into the output register, so a word
// can be taken every cycle unless the output stalls. Load words give no result.
// Reset clears the sequencer to idle and restores both configuration registers.
// A stalled output blocks input only while the output register is full and not being taken.
module i2c_master_write_sequencer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] data_byte, [8] sda_in, [15:9] zero
  input  logic        s_axis_tlast,   // last_byte
  input  logic        s_axis_tuser,   // opcode
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] scl_level, [1] sda_level, [2] want_byte,
                                      // [3] nack_seen, [7:4] zero
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i
);
  import i2cmws_pkg::*;

  logic [7:0] dev_addr_q;
  logic [7:0] ctrl_byte_q;

  seq_state_e state_q, state_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bit_cnt_q, bit_cnt_d;
  logic       phase_high_q, phase_high_d;
  logic       pend_q, pend_d;
  logic       pend_last_q, pend_last_d;
  logic       drop_q, drop_d;

  logic       out_valid_q, out_valid_d;
  phase_res_t res_q, res_d;

  logic       in_fire;
  logic       tick_fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign tick_fire     = in_fire && (s_axis_tuser == OpTick);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q  <= DevAddrRst;
      ctrl_byte_q <= CtrlByteRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CfgDevAddr) begin
        dev_addr_q <= cfg_data_i;
      end else begin
        ctrl_byte_q <= cfg_data_i;
      end
    end
  end

  // sequencer next state and phase result
  always_comb begin
    seq_state_e st;
    logic [3:0] bc;
    logic       ph;
    logic [7:0] cur_byte;
    logic       ack_slot;
    logic       want_now;

    state_d      = state_q;
    shift_d      = shift_q;
    bit_cnt_d    = bit_cnt_q;
    phase_high_d = phase_high_q;
    pend_d       = pend_q;
    pend_last_d  = pend_last_q;
    drop_d       = drop_q;
    res_d        = res_q;
    st           = state_q;
    bc           = bit_cnt_q;
    ph           = phase_high_q;
    cur_byte     = shift_q;
    ack_slot     = 1'b0;
    want_now     = drop_q || (!pend_q && (state_q == SeqIdle || state_q == SeqWait));

    if (in_fire && s_axis_tuser == OpLoad) begin
      // byte load
      if (drop_q) begin
        if (s_axis_tlast) begin
          drop_d = 1'b0;
        end
      end else if (want_now) begin
        shift_d     = s_axis_tdata[7:0];
        pend_last_d = s_axis_tlast;
        pend_d      = 1'b1;
      end
    end else if (tick_fire) begin
      res_d.scl_level = 1'b1;
      res_d.sda_level = 1'b1;
      res_d.nack_seen = 1'b0;

      // waiting with a fresh byte restarts the data sequence
      if (state_q == SeqWait && pend_q) begin
        st = SeqData;
        bc = '0;
        ph = 1'b0;
      end
      state_d      = st;
      bit_cnt_d    = bc;
      phase_high_d = ph;

      case (st)
        SeqAddr, SeqCtrl, SeqData: begin
          if (st == SeqAddr) begin
            cur_byte = dev_addr_q;
          end else if (st == SeqCtrl) begin
            cur_byte = ctrl_byte_q;
          end else begin
            cur_byte = shift_q;
          end
          ack_slot        = (bc >= AckSlot);
          res_d.scl_level = ph;
          res_d.sda_level = ack_slot ? 1'b1 : cur_byte[~bc[2:0]];
          if (!ph) begin
            phase_high_d = 1'b1;
          end else begin
            phase_high_d = 1'b0;
            if (!ack_slot) begin
              bit_cnt_d = bc + 4'd1;
            end else begin
              bit_cnt_d = '0;
              if (st == SeqAddr) begin
                if (s_axis_tdata[8]) begin
                  res_d.nack_seen = 1'b1;
                  drop_d          = !pend_last_q;
                  pend_d          = 1'b0;
                  pend_last_d     = 1'b0;
                  state_d         = SeqStop;
                end else begin
                  state_d = SeqCtrl;
                end
              end else if (st == SeqCtrl) begin
                state_d = SeqData;
              end else begin
                pend_d      = 1'b0;
                state_d     = pend_last_q ? SeqStop : SeqWait;
                pend_last_d = 1'b0;
              end
            end
          end
        end
        SeqWait: begin
          // clock held low between bytes
          res_d.scl_level = 1'b0;
          res_d.sda_level = 1'b1;
        end
        SeqStop: begin
          res_d.scl_level = (bc != 4'd0);
          res_d.sda_level = (bc >= StopLast);
          if (bc >= StopLast) begin
            bit_cnt_d = '0;
            state_d   = SeqIdle;
          end else begin
            bit_cnt_d = bc + 4'd1;
          end
        end
        default: begin
          // idle: start condition when a byte is pending
          state_d = SeqIdle;
          if (pend_q) begin
            res_d.sda_level = 1'b0;
            state_d         = SeqAddr;
            bit_cnt_d       = '0;
            phase_high_d    = 1'b0;
          end
        end
      endcase

      res_d.want_byte = drop_d ||
                        (!pend_d && (state_d == SeqIdle || state_d == SeqWait));
    end
  end

  // output register occupancy
  always_comb begin
    if (tick_fire) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SeqIdle;
      shift_q      <= '0;
      bit_cnt_q    <= '0;
      phase_high_q <= 1'b0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      drop_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      shift_q      <= shift_d;
      bit_cnt_q    <= bit_cnt_d;
      phase_high_q <= phase_high_d;
      pend_q       <= pend_d;
      pend_last_q  <= pend_last_d;
      drop_q       <= drop_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, res_q};

endmodule

@@ verif/tb.sv @@
// self-checking testbench for the i2c master write sequencer unit
module tb;
  import i2cmws_pkg::*;

  // one input word as the generator sees it
  typedef struct packed {
    logic       opcode;
    logic [7:0] data;
    logic       last;
    logic       sda;
  } word_t;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       s_axis_tvalid  = 1'b0;
  logic       s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic       s_axis_tlast   = 1'b0;
  logic       s_axis_tuser   = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready  = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       cfg_we_i       = 1'b0;
  logic       cfg_idx_i      = 1'b0;
  logic [7:0] cfg_data_i     = '0;

  // stimulus and expectation stores
  word_t      word_q[$];
  phase_res_t bus_phase_q[$];
  word_t      word_on_bus;
  int         src_idle_pct  = 0;
  int         snk_stall_pct = 0;
  int         err_count     = 0;
  int         res_count     = 0;

  // shadow copy of the sequencer
  logic [7:0] dev_addr;
  logic [7:0] ctrl_byte;
  logic [7:0] shift_byte;
  logic [3:0] bit_cnt;
  logic       phase_hi;
  seq_state_e seq_st;
  logic       byte_held;
  logic       held_last;
  logic       drop_mode;

  i2c_master_write_sequencer_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte, [8] sda_in, [15:9] zero
    .s_axis_tlast  (s_axis_tlast),   // last_byte
    .s_axis_tuser  (s_axis_tuser),   // opcode
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [0] scl_level, [1] sda_level, [2] want_byte,
                                     // [3] nack_seen, [7:4] zero
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic ready_for_byte();
    if (drop_mode) return 1'b1;
    if (byte_held) return 1'b0;
    return (seq_st == SeqIdle) || (seq_st == SeqWait);
  endfunction

  task automatic clear_shadow();
    dev_addr   = DevAddrRst;
    ctrl_byte  = CtrlByteRst;
    shift_byte = '0;
    bit_cnt    = '0;
    phase_hi   = 1'b0;
    seq_st     = SeqIdle;
    byte_held  = 1'b0;
    held_last  = 1'b0;
    drop_mode  = 1'b0;
  endtask

  // advance the shadow sequencer by one word, queue the phase it drives
  task automatic advance_bus(input word_t w);
    phase_res_t res;
    logic [7:0] cur;
    logic       ack;
    res = '{nack_seen: 1'b0, want_byte: 1'b0, sda_level: 1'b1, scl_level: 1'b1};
    if (w.opcode == OpLoad) begin
      if (drop_mode) begin
        if (w.last) drop_mode = 1'b0;
      end else if (ready_for_byte()) begin
        shift_byte = w.data;
        held_last  = w.last;
        byte_held  = 1'b1;
      end
      return;
    end
    // a byte waiting in the gap between data bytes starts the next one
    if (seq_st == SeqWait && byte_held) begin
      seq_st   = SeqData;
      bit_cnt  = '0;
      phase_hi = 1'b0;
    end
    case (seq_st)
      SeqAddr, SeqCtrl, SeqData: begin
        cur = (seq_st == SeqAddr) ? dev_addr : (seq_st == SeqCtrl) ? ctrl_byte : shift_byte;
        ack = (bit_cnt >= AckSlot);
        res.scl_level = phase_hi;
        res.sda_level = ack ? 1'b1 : cur[~bit_cnt[2:0]];
        if (!phase_hi) begin
          phase_hi = 1'b1;
        end else begin
          phase_hi = 1'b0;
          if (!ack) begin
            bit_cnt = bit_cnt + 4'd1;
          end else begin
            bit_cnt = '0;
            if (seq_st == SeqAddr) begin
              if (w.sda) begin
                res.nack_seen = 1'b1;
                drop_mode = !held_last;
                byte_held = 1'b0;
                held_last = 1'b0;
                seq_st    = SeqStop;
              end else begin
                seq_st = SeqCtrl;
              end
            end else if (seq_st == SeqCtrl) begin
              seq_st = SeqData;
            end else begin
              byte_held = 1'b0;
              seq_st    = held_last ? SeqStop : SeqWait;
              held_last = 1'b0;
            end
          end
        end
      end
      SeqWait: begin
        res.scl_level = 1'b0;
        res.sda_level = 1'b1;
      end
      SeqStop: begin
        res.scl_level = (bit_cnt != 4'd0);
        res.sda_level = (bit_cnt >= StopLast);
        if (bit_cnt >= StopLast) begin
          bit_cnt = '0;
          seq_st  = SeqIdle;
        end else begin
          bit_cnt = bit_cnt + 4'd1;
        end
      end
      default: begin
        seq_st = SeqIdle;
        if (byte_held) begin
          // start condition
          res.sda_level = 1'b0;
          seq_st   = SeqAddr;
          bit_cnt  = '0;
          phase_hi = 1'b0;
        end
      end
    endcase
    res.want_byte = ready_for_byte();
    bus_phase_q.push_back(res);
  endtask

  // input driver, predicts each word as it is taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      clear_shadow();
    end else begin
      if (s_axis_tvalid && s_axis_tready) advance_bus(word_on_bus);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (word_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          word_on_bus = word_q.pop_front();
          s_axis_tdata  <= {7'b0, word_on_bus.sda, word_on_bus.data};
          s_axis_tlast  <= word_on_bus.last;
          s_axis_tuser  <= word_on_bus.opcode;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic note_mismatch(input string fld, input logic e, input logic a);
    err_count++;
    if (err_count <= 10)
      $display("mismatch in %s of result %0d: expected %b, got %b", fld, res_count, e, a);
  endtask

  // output monitor and checker
  always @(posedge clk_i) begin
    phase_res_t want_res;
    phase_res_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = phase_res_t'(m_axis_tdata[3:0]);
        if (bus_phase_q.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("unexpected result word %h", m_axis_tdata);
        end else begin
          want_res = bus_phase_q.pop_front();
          if (got.scl_level !== want_res.scl_level)
            note_mismatch("scl_level", want_res.scl_level, got.scl_level);
          if (got.sda_level !== want_res.sda_level)
            note_mismatch("sda_level", want_res.sda_level, got.sda_level);
          if (got.want_byte !== want_res.want_byte)
            note_mismatch("want_byte", want_res.want_byte, got.want_byte);
          if (got.nack_seen !== want_res.nack_seen)
            note_mismatch("nack_seen", want_res.nack_seen, got.nack_seen);
        end
        res_count++;
      end
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // word builders
  task automatic queue_load(input logic [7:0] d, input logic last);
    word_q.push_back('{opcode: OpLoad, data: d, last: last, sda: 1'($urandom_range(1))});
  endtask

  task automatic queue_tick(input logic sda);
    word_q.push_back('{opcode: OpTick, data: 8'($urandom_range(255)),
                       last: 1'($urandom_range(1)), sda: sda});
  endtask

  task automatic queue_ticks(input int n);
    repeat (n) queue_tick(1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // well-formed write of n bytes, address optionally refused
  task automatic queue_transfer(input int n, input logic refuse);
    queue_ticks($urandom_range(2));
    queue_load(pick_byte(), n == 1);
    queue_ticks(18);               // start phase, address bits and ack low phase
    queue_tick(refuse);            // address ack sampled here
    if (refuse) begin
      queue_ticks(3);
      for (int k = 1; k < n; k++) begin
        queue_ticks($urandom_range(1));
        queue_load(pick_byte(), k == n - 1);
      end
      return;
    end
    queue_ticks(36);               // control byte and first data byte
    for (int k = 1; k < n; k++) begin
      queue_ticks($urandom_range(3));
      queue_load(pick_byte(), k == n - 1);
      queue_ticks(18);
    end
    queue_ticks(3 + $urandom_range(2));
  endtask

  // random words, then two closing writes to bring the bus back to idle
  task automatic queue_noise(input int n);
    repeat (n) begin
      if ($urandom_range(1)) queue_tick(1'($urandom_range(1)));
      else queue_load(pick_byte(), $urandom_range(3) == 0);
    end
    repeat (2) begin
      queue_load(pick_byte(), 1'b1);
      repeat (60) queue_tick(1'b0);
    end
  endtask

  task automatic drain();
    do @(negedge clk_i);
    while (word_q.size() > 0 || s_axis_tvalid || bus_phase_q.size() > 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_registers(input logic [7:0] addr, input logic [7:0] ctrl);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgDevAddr;
    cfg_data_i <= addr;
    dev_addr    = addr;
    @(posedge clk_i);
    cfg_idx_i  <= CfgCtrlByte;
    cfg_data_i <= ctrl;
    ctrl_byte   = ctrl;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // reset and stimulus sequence
  initial begin
    int src_pct[4] = '{0, 49, 0, 32};
    int snk_pct[4] = '{0, 0, 49, 32};
    logic [7:0] addr_set[4] = '{8'h00, 8'hFF, 8'hA5, 8'h78};
    logic [7:0] ctrl_set[4] = '{8'hFF, 8'h00, 8'h5A, 8'h81};
    int start_len;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle bus, load while a byte is held, refused address, drop mode
    queue_tick(1'b0);
    queue_load(8'h00, 1'b0);
    queue_load(8'hFF, 1'b1);
    queue_ticks(18);
    queue_tick(1'b1);
    queue_ticks(3);
    queue_load(8'hFF, 1'b0);
    queue_load(8'h00, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      set_registers(p == 2 ? pick_byte() : addr_set[p], p == 2 ? pick_byte() : ctrl_set[p]);
      src_idle_pct  = src_pct[p];
      snk_stall_pct = snk_pct[p];
      start_len = 0;
      while (start_len < 300) begin
        int before_len;
        before_len = word_q.size();
        if ($urandom_range(9) < 8) queue_transfer($urandom_range(1, 3), $urandom_range(5) == 0);
        else queue_noise($urandom_range(5, 20));
        start_len += word_q.size() - before_len;
      end
      drain();
    end

    repeat (8) @(negedge clk_i);
    if (err_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // run time limit
  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/i2cmws_pkg.sv
rtl/core/i2c_master_write_sequencer_unit.sv
verif/tb.sv
